[rtl/wdtk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdtk_pkg: shared types and constants for the toggle-kick watchdog
// Item layouts, command codes, register offsets and countdown sizing.
// ----------------------------------------------------------------------------
package wdtk_pkg;

	// Milliseconds per period unit of the control register
	localparam int unsigned MS_PER_UNIT = 2;

	localparam int unsigned WORD_W   = 16;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned PERIOD_W = 15;
	localparam int unsigned REMAIN_W = 17;
	localparam int unsigned UNIT_W   = $clog2(MS_PER_UNIT + 1);
	localparam int unsigned PROD_W   =
		(PERIOD_W + UNIT_W > REMAIN_W) ? (PERIOD_W + UNIT_W) : REMAIN_W;

	localparam int unsigned ENABLE_BIT = 15;

	localparam logic [ADDR_W-1:0]   ADDR_CONTROL  = 5'h10;
	localparam logic [ADDR_W-1:0]   ADDR_KICK     = 5'h14;
	localparam logic [WORD_W-1:0]   CONTROL_RESET = 16'h7fff;
	localparam logic [WORD_W-1:0]   KICK_RESET    = 16'h5555;
	localparam logic [WORD_W-1:0]   WORD_MASK     = 16'hffff;
	localparam logic [REMAIN_W-1:0] REMAIN_MAX    = 17'h1ffff;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              fired;
	} out_item_t;

	// Item handed from the input register to the register file
	typedef struct packed {
		logic     step;
		in_item_t item;
	} step_t;

endpackage

[rtl/wdtk_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdtk_core: watchdog registers and countdown
// Holds control, kick, armed and remaining state; decodes one item per
// step and forms its result combinationally.
// ----------------------------------------------------------------------------
module wdtk_core import wdtk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_t     req,
	output out_item_t res
);

	logic [WORD_W-1:0]   control_q, control_d;
	logic [WORD_W-1:0]   kick_q, kick_d;
	logic                armed_q, armed_d;
	logic [REMAIN_W-1:0] remain_q, remain_d;

	logic [PERIOD_W-1:0] period_src;
	logic [PROD_W-1:0]   prod;
	logic [REMAIN_W-1:0] load_ms;
	logic                was_on, now_on, kick_ok;

	// A control write arms from the period it carries
	assign period_src = (req.item.command == CMD_WRITE && req.item.address == ADDR_CONTROL)
		? req.item.write_data[PERIOD_W-1:0] : control_q[PERIOD_W-1:0];
	assign prod    = PROD_W'(period_src) * PROD_W'(MS_PER_UNIT);
	assign load_ms = (prod > PROD_W'(REMAIN_MAX)) ? REMAIN_MAX : prod[REMAIN_W-1:0];
	assign was_on  = control_q[ENABLE_BIT];
	assign now_on  = req.item.write_data[ENABLE_BIT];
	assign kick_ok = (req.item.write_data == (kick_q ^ WORD_MASK));

	always_comb begin
		control_d     = control_q;
		kick_d        = kick_q;
		armed_d       = armed_q;
		remain_d      = remain_q;
		res.read_data = '0;
		res.fired     = 1'b0;
		case (req.item.command)
			CMD_READ: begin
				if (req.item.address == ADDR_CONTROL) begin
					res.read_data = control_q;
				end else if (req.item.address == ADDR_KICK) begin
					res.read_data = kick_q;
				end
			end
			CMD_WRITE: begin
				if (req.item.address == ADDR_CONTROL) begin
					control_d = req.item.write_data;
					if (was_on && !now_on) begin
						armed_d  = 1'b0;
						remain_d = '0;
					end else if (!was_on && now_on) begin
						armed_d  = 1'b1;
						remain_d = load_ms;
					end
				end else if (req.item.address == ADDR_KICK && kick_ok) begin
					kick_d   = req.item.write_data;
					armed_d  = 1'b1;
					remain_d = load_ms;
				end
			end
			CMD_TICK: begin
				if (armed_q) begin
					if (remain_q <= REMAIN_W'(1)) begin
						res.fired = 1'b1;
						armed_d   = 1'b0;
						remain_d  = '0;
					end else begin
						remain_d = remain_q - REMAIN_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= CONTROL_RESET;
			kick_q    <= KICK_RESET;
			armed_q   <= 1'b0;
			remain_q  <= '0;
		end else if (req.step) begin
			control_q <= control_d;
			kick_q    <= kick_d;
			armed_q   <= armed_d;
			remain_q  <= remain_d;
		end
	end

	// A disarmed countdown always holds zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> remain_q == '0)
		else $error("disarmed countdown not zero");

	// Kick word only ever toggles between the two patterns
	a_kick_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		kick_q == KICK_RESET || kick_q == ~KICK_RESET)
		else $error("kick word left toggle pattern");

	// Firing disarms the countdown
	a_fire_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		req.step && res.fired |=> !armed_q)
		else $error("countdown still armed after firing");

	// An accepted kick leaves the countdown armed
	a_kick_arms: assert property (@(posedge clk) disable iff (!arst_n)
		req.step && req.item.command == CMD_WRITE && req.item.address == ADDR_KICK
		&& kick_ok |=> armed_q)
		else $error("accepted kick did not arm");

endmodule

[rtl/watchdog_toggle_kick_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchdog_toggle_kick_timer: tick-driven watchdog with toggle-pattern kick
// Path: item held in the input register on accept, then the result register
//   loads as the state updates, once the output stage is free.
// Throughput: one item per cycle while result_stall does not hold the output.
// Reset: arst_n clears both stages' valid flags; control 0x7fff, kick 0x5555, disarmed.
// ----------------------------------------------------------------------------
module watchdog_toggle_kick_timer import wdtk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic      s1_valid_q;
	in_item_t  item_s1;
	logic      result_valid_q;
	out_item_t result_s2;
	logic      s2_free;
	step_t     req;
	out_item_t res;

	assign s2_free    = !result_valid_q || !result_stall;
	assign item_stall = s1_valid_q && !s2_free;

	assign req.step = s1_valid_q && s2_free;
	assign req.item = item_s1;

	wdtk_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				s1_valid_q <= item_valid;
			end
			if (s2_free) begin
				result_valid_q <= s1_valid_q;
			end
		end
	end

	// Payload stages: hold while stalled
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (req.step) begin
			result_s2 <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_s2;

endmodule
